### src/tcqm_pkg.sv
// Shared types, constants and match functions for the trinucleotide context quota matcher.
package tcqm_pkg;

    localparam int TABLE_DEPTH_DEF = 96;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    localparam int BASE_W  = 3;
    localparam int SUB_W   = 2;
    localparam int QUOTA_W = 32;
    localparam int TAG_W   = 16;
    localparam int POS_W   = 40;

    localparam logic [BASE_W-1:0] BASE_MAX = 3'd3;
    localparam logic [SUB_W-1:0]  BASE_T   = 2'd3;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef struct packed {
        logic [BASE_W-1:0]  b0;
        logic [BASE_W-1:0]  b1;
        logic [BASE_W-1:0]  b2;
        logic [SUB_W-1:0]   sub;
        logic [QUOTA_W-1:0] quota;
    } ctx_entry_t;

    localparam int ENTRY_W = $bits(ctx_entry_t);

    typedef struct packed {
        op_t                op;
        logic [BASE_W-1:0]  base_left;
        logic [BASE_W-1:0]  base_mid;
        logic [BASE_W-1:0]  base_right;
        logic [SUB_W-1:0]   sub;
        logic [QUOTA_W-1:0] quota;
        logic [TAG_W-1:0]   tag;
        logic [POS_W-1:0]   pos;
    } item_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
    } front_stat_t;

    typedef struct packed {
        logic scanning;
        logic none_left;
    } back_stat_t;

    function automatic logic [SUB_W-1:0] comp_base(input logic [SUB_W-1:0] b);
        return BASE_T - b;
    endfunction

    function automatic logic base_eq(input logic [BASE_W-1:0] a, input logic [BASE_W-1:0] b);
        return (a <= BASE_MAX) && (b <= BASE_MAX) && (a == b);
    endfunction

    function automatic logic fwd_hit(input ctx_entry_t e, input logic [BASE_W-1:0] ql,
                                     input logic [BASE_W-1:0] qm, input logic [BASE_W-1:0] qr);
        return base_eq(e.b0, ql) && base_eq(e.b1, qm) && base_eq(e.b2, qr);
    endfunction

    function automatic logic rev_hit(input ctx_entry_t e, input logic [BASE_W-1:0] ql,
                                     input logic [BASE_W-1:0] qm, input logic [BASE_W-1:0] qr);
        logic valid_bases;
        valid_bases = (e.b0 <= BASE_MAX) && (e.b1 <= BASE_MAX) && (e.b2 <= BASE_MAX);
        return valid_bases
            && base_eq({1'b0, comp_base(e.b2[SUB_W-1:0])}, ql)
            && base_eq({1'b0, comp_base(e.b1[SUB_W-1:0])}, qm)
            && base_eq({1'b0, comp_base(e.b0[SUB_W-1:0])}, qr);
    endfunction

endpackage

### src/tcqm_ram.sv
// Generic single write port, single read port RAM with registered read data.
module tcqm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/tcqm_front.sv
// Front end: accepts commands and holds them in a short queue for the back end.
module tcqm_front import tcqm_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  item_t       in_item,
    output logic        busy,
    output logic        head_valid,
    output item_t       head_item,
    input  logic        pop,
    output front_stat_t stat
);

    item_t               q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                push;
    logic                take;

    assign busy       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = q_mem[rd_ptr_reg];
    assign push       = start && !busy;
    assign take       = pop && head_valid;
    assign stat.count = count_reg;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = take ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !take)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (take && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

### src/tcqm_back.sv
// Back end: stores loaded contexts and scans them one entry per cycle for each query.
module tcqm_back import tcqm_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  item_t              head_item,
    output logic               pop,
    output logic               result_valid,
    output logic               matched,
    output logic               on_reverse,
    output logic [SUB_W-1:0]   result_sub_base,
    output logic [TAG_W-1:0]   result_contig_tag,
    output logic [POS_W-1:0]   target_position,
    output logic               all_done,
    output back_stat_t         stat
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      nonzero_reg, nonzero_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [BASE_W-1:0]  ql_reg, ql_next;
    logic [BASE_W-1:0]  qm_reg, qm_next;
    logic [BASE_W-1:0]  qr_reg, qr_next;
    logic [TAG_W-1:0]   tag_reg, tag_next;
    logic [POS_W-1:0]   pos_reg, pos_next;

    logic               rv_reg, rv_next;
    logic               match_reg, match_next;
    logic               rev_reg, rev_next;
    logic [SUB_W-1:0]   sub_reg, sub_next;
    logic [TAG_W-1:0]   rtag_reg, rtag_next;
    logic [POS_W-1:0]   rpos_reg, rpos_next;
    logic               done_reg, done_next;

    logic               we;
    logic [AW-1:0]      waddr;
    ctx_entry_t         wentry;
    logic [ENTRY_W-1:0] rdata;
    ctx_entry_t         ent;
    logic               hit_f;
    logic               hit_r;

    tcqm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wentry),
        .raddr (idx_next),
        .rdata (rdata)
    );

    assign ent   = ctx_entry_t'(rdata);
    assign hit_f = (ent.quota != '0) && fwd_hit(ent, ql_reg, qm_reg, qr_reg);
    assign hit_r = (ent.quota != '0) && !hit_f && rev_hit(ent, ql_reg, qm_reg, qr_reg);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        nonzero_next = nonzero_reg;
        idx_next     = idx_reg;
        ql_next      = ql_reg;
        qm_next      = qm_reg;
        qr_next      = qr_reg;
        tag_next     = tag_reg;
        pos_next     = pos_reg;
        rv_next      = 1'b0;
        match_next   = match_reg;
        rev_next     = rev_reg;
        sub_next     = sub_reg;
        rtag_next    = rtag_reg;
        rpos_next    = rpos_reg;
        done_next    = done_reg;
        pop          = 1'b0;
        we           = 1'b0;
        waddr        = idx_reg;
        wentry       = ent;

        case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    pop = 1'b1;
                    if (head_item.op == OP_LOAD)
                    begin
                        if (count_reg < CW'(TABLE_DEPTH))
                        begin
                            we           = 1'b1;
                            waddr        = count_reg[AW-1:0];
                            wentry.b0    = head_item.base_left;
                            wentry.b1    = head_item.base_mid;
                            wentry.b2    = head_item.base_right;
                            wentry.sub   = head_item.sub;
                            wentry.quota = head_item.quota;
                            count_next   = count_reg + CW'(1);
                            if (head_item.quota != '0)
                            begin
                                nonzero_next = nonzero_reg + CW'(1);
                            end
                        end
                    end
                    else
                    begin
                        ql_next  = head_item.base_left;
                        qm_next  = head_item.base_mid;
                        qr_next  = head_item.base_right;
                        tag_next = head_item.tag;
                        pos_next = head_item.pos + POS_W'(1);
                        idx_next = '0;
                        if (count_reg == '0)
                        begin
                            rv_next    = 1'b1;
                            match_next = 1'b0;
                            rev_next   = 1'b0;
                            sub_next   = '0;
                            rtag_next  = head_item.tag;
                            rpos_next  = head_item.pos + POS_W'(1);
                            done_next  = (nonzero_reg == '0);
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                if (hit_f || hit_r)
                begin
                    we           = 1'b1;
                    waddr        = idx_reg;
                    wentry.quota = ent.quota - QUOTA_W'(1);
                    if (ent.quota == QUOTA_W'(1))
                    begin
                        nonzero_next = nonzero_reg - CW'(1);
                    end
                    rv_next    = 1'b1;
                    match_next = 1'b1;
                    rev_next   = hit_r;
                    sub_next   = hit_r ? comp_base(ent.sub) : ent.sub;
                    rtag_next  = tag_reg;
                    rpos_next  = pos_reg;
                    done_next  = (nonzero_next == '0);
                    state_next = S_IDLE;
                end
                else if ((CW'(idx_reg) + CW'(1)) < count_reg)
                begin
                    idx_next = idx_reg + AW'(1);
                end
                else
                begin
                    rv_next    = 1'b1;
                    match_next = 1'b0;
                    rev_next   = 1'b0;
                    sub_next   = '0;
                    rtag_next  = tag_reg;
                    rpos_next  = pos_reg;
                    done_next  = (nonzero_reg == '0);
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            nonzero_reg <= '0;
            idx_reg     <= '0;
            ql_reg      <= '0;
            qm_reg      <= '0;
            qr_reg      <= '0;
            tag_reg     <= '0;
            pos_reg     <= '0;
            rv_reg      <= 1'b0;
            match_reg   <= 1'b0;
            rev_reg     <= 1'b0;
            sub_reg     <= '0;
            rtag_reg    <= '0;
            rpos_reg    <= '0;
            done_reg    <= 1'b1;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            nonzero_reg <= nonzero_next;
            idx_reg     <= idx_next;
            ql_reg      <= ql_next;
            qm_reg      <= qm_next;
            qr_reg      <= qr_next;
            tag_reg     <= tag_next;
            pos_reg     <= pos_next;
            rv_reg      <= rv_next;
            match_reg   <= match_next;
            rev_reg     <= rev_next;
            sub_reg     <= sub_next;
            rtag_reg    <= rtag_next;
            rpos_reg    <= rpos_next;
            done_reg    <= done_next;
        end
    end

    assign result_valid      = rv_reg;
    assign matched           = match_reg;
    assign on_reverse        = rev_reg;
    assign result_sub_base   = sub_reg;
    assign result_contig_tag = rtag_reg;
    assign target_position   = rpos_reg;
    assign all_done          = done_reg;
    assign stat.scanning     = (state_reg == S_SCAN);
    assign stat.none_left    = (nonzero_reg == '0);

endmodule

### src/trinucleotide_context_quota_matcher.sv
// Top level of the trinucleotide context quota matcher: command queue and context scanner.
//
//   Channel  | Handshake            | Payload
//   ---------+----------------------+-------------------------------------------------------
//   command  | start / busy         | operation, base_left, base_mid, base_right,
//            |                      | load_sub_base, load_quota, contig_tag, locus_position
//   result   | result_valid strobe  | matched, on_reverse, result_sub_base,
//            |                      | result_contig_tag, target_position, all_done
//
// A command transfer happens when start is high and busy is low; busy is high only while the
// two-entry command queue is full. A load is written into the table as it leaves the queue,
// unless the table is full. A query's result strobe follows a scan of at most the loaded
// count of entries, one entry per cycle through the registered table read.
// A result transfer lasts exactly one cycle and cannot be stalled. Reset empties the queue,
// the loaded count and the nonzero quota count; table contents are not cleared.
module trinucleotide_context_quota_matcher import tcqm_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               operation,
    input  logic [BASE_W-1:0]  base_left,
    input  logic [BASE_W-1:0]  base_mid,
    input  logic [BASE_W-1:0]  base_right,
    input  logic [SUB_W-1:0]   load_sub_base,
    input  logic [QUOTA_W-1:0] load_quota,
    input  logic [TAG_W-1:0]   contig_tag,
    input  logic [POS_W-1:0]   locus_position,
    output logic               result_valid,
    output logic               matched,
    output logic               on_reverse,
    output logic [SUB_W-1:0]   result_sub_base,
    output logic [TAG_W-1:0]   result_contig_tag,
    output logic [POS_W-1:0]   target_position,
    output logic               all_done
);

    item_t       in_item;
    item_t       head_item;
    logic        head_valid;
    logic        pop;
    front_stat_t fstat;
    back_stat_t  bstat;

    always_comb
    begin
        in_item.op         = op_t'(operation);
        in_item.base_left  = base_left;
        in_item.base_mid   = base_mid;
        in_item.base_right = base_right;
        in_item.sub        = load_sub_base;
        in_item.quota      = load_quota;
        in_item.tag        = contig_tag;
        in_item.pos        = locus_position;
    end

    tcqm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .in_item    (in_item),
        .busy       (busy),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .stat       (fstat)
    );

    tcqm_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .head_valid        (head_valid),
        .head_item         (head_item),
        .pop               (pop),
        .result_valid      (result_valid),
        .matched           (matched),
        .on_reverse        (on_reverse),
        .result_sub_base   (result_sub_base),
        .result_contig_tag (result_contig_tag),
        .target_position   (target_position),
        .all_done          (all_done),
        .stat              (bstat)
    );

    a_nomatch_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !matched |-> !on_reverse && (result_sub_base == '0))
        else $error("unmatched result carries strand or substitution data");

    a_done_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (all_done == bstat.none_left))
        else $error("all_done disagrees with the nonzero quota count");

    a_match_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && matched |-> $past(bstat.scanning))
        else $error("matched result without a preceding table scan");

    a_busy_full: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (fstat.count == QCNT_W'(QUEUE_DEPTH)) && head_valid)
        else $error("busy raised while the command queue has room");

endmodule

### dv/trinucleotide_context_quota_matcher_tb.sv
// Self-checking testbench for the trinucleotide context quota matcher.
module trinucleotide_context_quota_matcher_tb;
    import tcqm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD = 10;
    localparam int DEPTH      = TABLE_DEPTH_DEF;
    localparam int N_ITEMS    = 850;
    localparam int LIMIT      = 400_000;

    localparam logic [BASE_W-1:0] NT_A = 3'd0;
    localparam logic [BASE_W-1:0] NT_C = 3'd1;
    localparam logic [BASE_W-1:0] NT_G = 3'd2;
    localparam logic [BASE_W-1:0] NT_T = 3'd3;
    localparam logic [BASE_W-1:0] NT_N = 3'd4;

    localparam logic [SUB_W-1:0] SB_A = 2'd0;
    localparam logic [SUB_W-1:0] SB_C = 2'd1;
    localparam logic [SUB_W-1:0] SB_G = 2'd2;
    localparam logic [SUB_W-1:0] SB_T = 2'd3;

    typedef struct packed {
        logic               matched;
        logic               on_rev;
        logic [SUB_W-1:0]   sub;
        logic [TAG_W-1:0]   tag;
        logic [POS_W-1:0]   pos;
        logic               done;
    } result_t;

    typedef struct packed {
        item_t   cmd;
        logic    pinned;
        result_t want;
    } row_t;

    localparam int DIRECTED_ROWS = 20;
    localparam row_t DIRECTED [DIRECTED_ROWS] = '{
        '{'{OP_QUERY, NT_A, NT_C, NT_G, SB_A, 32'd0, 16'h0000, 40'h0}, 1'b1,
          '{1'b0, 1'b0, SB_A, 16'h0000, 40'h1, 1'b1}},
        '{'{OP_QUERY, NT_N, NT_N, NT_N, SB_T, 32'hFFFF_FFFF, 16'hFFFF, 40'hFF_FFFF_FFFF}, 1'b1,
          '{1'b0, 1'b0, SB_A, 16'hFFFF, 40'h0, 1'b1}},
        '{'{OP_LOAD,  NT_A, NT_C, NT_G, SB_T, 32'd2, 16'h0000, 40'h0}, 1'b0, '0},
        '{'{OP_LOAD,  NT_C, NT_C, NT_C, SB_A, 32'd0, 16'h0000, 40'h0}, 1'b0, '0},
        '{'{OP_LOAD,  NT_N, NT_A, NT_A, SB_G, 32'd0, 16'h0000, 40'h0}, 1'b0, '0},
        '{'{OP_QUERY, NT_A, NT_C, NT_G, SB_A, 32'd0, 16'h0001, 40'd100}, 1'b0, '0},
        '{'{OP_QUERY, NT_C, NT_G, NT_T, SB_A, 32'd0, 16'h0002, 40'd200}, 1'b0, '0},
        '{'{OP_QUERY, NT_A, NT_C, NT_G, SB_A, 32'd0, 16'h0003, 40'd300}, 1'b0, '0},
        '{'{OP_QUERY, NT_C, NT_C, NT_C, SB_A, 32'd0, 16'h0004, 40'd400}, 1'b0, '0},
        '{'{OP_QUERY, NT_N, NT_A, NT_A, SB_A, 32'd0, 16'h0005, 40'd500}, 1'b0, '0},
        '{'{OP_LOAD,  NT_A, NT_T, NT_A, SB_C, 32'd1, 16'h0000, 40'h0}, 1'b0, '0},
        '{'{OP_LOAD,  NT_T, NT_A, NT_T, SB_G, 32'd1, 16'h0000, 40'h0}, 1'b0, '0},
        '{'{OP_QUERY, NT_T, NT_A, NT_T, SB_A, 32'd0, 16'h0006, 40'd600}, 1'b0, '0},
        '{'{OP_QUERY, NT_T, NT_A, NT_T, SB_A, 32'd0, 16'h0007, 40'd700}, 1'b0, '0},
        '{'{OP_LOAD,  NT_G, NT_G, NT_G, SB_C, 32'd2, 16'h0000, 40'h0}, 1'b0, '0},
        '{'{OP_QUERY, NT_C, NT_C, NT_C, SB_A, 32'd0, 16'h0008, 40'd800}, 1'b0, '0},
        '{'{OP_QUERY, NT_G, NT_G, NT_G, SB_A, 32'd0, 16'h8000, 40'h7F_FFFF_FFFF}, 1'b0, '0},
        '{'{OP_QUERY, NT_G, NT_G, NT_N, SB_A, 32'd0, 16'h0009, 40'd900}, 1'b0, '0},
        '{'{OP_QUERY, NT_G, NT_G, NT_G, SB_A, 32'd0, 16'h000A, 40'd1000}, 1'b0, '0},
        '{'{OP_QUERY, NT_T, NT_A, NT_T, SB_A, 32'd0, 16'h000B, 40'd1100}, 1'b0, '0}
    };

    logic    clk    = 1'b0;
    logic    rst_n  = 1'b0;
    logic    start  = 1'b0;
    item_t   cmd    = '0;
    logic    pinned = 1'b0;
    result_t pinned_want = '0;

    logic               busy;
    logic               result_valid;
    logic               matched;
    logic               on_reverse;
    logic [SUB_W-1:0]   result_sub_base;
    logic [TAG_W-1:0]   result_contig_tag;
    logic [POS_W-1:0]   target_position;
    logic               all_done;

    ctx_entry_t             ctx_store [DEPTH];
    int                     ctx_loaded = 0;
    result_t                pending_results [$];
    logic [3*BASE_W-1:0]    load_log [$];

    int fail_count   = 0;
    int cycle_count  = 0;
    int useful_items = 0;
    int n_queries    = 0;
    int n_fwd_hits   = 0;
    int n_rev_hits   = 0;
    int n_done_high  = 0;
    int n_full_loads = 0;

    trinucleotide_context_quota_matcher #(
        .TABLE_DEPTH(DEPTH)
    ) u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .operation        (cmd.op),
        .base_left        (cmd.base_left),
        .base_mid         (cmd.base_mid),
        .base_right       (cmd.base_right),
        .load_sub_base    (cmd.sub),
        .load_quota       (cmd.quota),
        .contig_tag       (cmd.tag),
        .locus_position   (cmd.pos),
        .result_valid     (result_valid),
        .matched          (matched),
        .on_reverse       (on_reverse),
        .result_sub_base  (result_sub_base),
        .result_contig_tag(result_contig_tag),
        .target_position  (target_position),
        .all_done         (all_done)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic logic same_base(input logic [BASE_W-1:0] a, input logic [BASE_W-1:0] b);
        return (a <= NT_T) && (a == b);
    endfunction

    function automatic logic [BASE_W-1:0] flip_base(input logic [BASE_W-1:0] b);
        return NT_T - b;
    endfunction

    task automatic store_context(input item_t it);
        if (ctx_loaded < DEPTH)
        begin
            ctx_store[ctx_loaded] = '{it.base_left, it.base_mid, it.base_right, it.sub, it.quota};
            ctx_loaded++;
        end
        else
        begin
            n_full_loads++;
        end
    endtask

    // Scans the table for the first live entry that matches the query and draws one off its quota.
    function automatic result_t scan_contexts(input item_t q);
        result_t    r;
        ctx_entry_t e;
        logic       all_valid;
        r     = '0;
        r.tag = q.tag;
        r.pos = q.pos + 40'd1;
        for (int i = 0; i < ctx_loaded; i++)
        begin
            e = ctx_store[i];
            all_valid = (e.b0 <= NT_T) && (e.b1 <= NT_T) && (e.b2 <= NT_T);
            if (!r.matched && e.quota != 0)
            begin
                if (same_base(e.b0, q.base_left) && same_base(e.b1, q.base_mid)
                    && same_base(e.b2, q.base_right))
                begin
                    r.matched = 1'b1;
                    r.sub     = e.sub;
                    ctx_store[i].quota = e.quota - 1;
                end
                else if (all_valid && same_base(flip_base(e.b2), q.base_left)
                         && same_base(flip_base(e.b1), q.base_mid)
                         && same_base(flip_base(e.b0), q.base_right))
                begin
                    r.matched = 1'b1;
                    r.on_rev  = 1'b1;
                    r.sub     = ~e.sub;
                    ctx_store[i].quota = e.quota - 1;
                end
            end
        end
        r.done = 1'b1;
        for (int i = 0; i < ctx_loaded; i++)
        begin
            if (ctx_store[i].quota != 0)
                r.done = 1'b0;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [POS_W-1:0] want,
                               input logic [POS_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (result_valid === 1'b1)
        begin
            got = '{matched, on_reverse, result_sub_base, result_contig_tag, target_position,
                    all_done};
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("matched", POS_W'(want.matched), POS_W'(got.matched));
                check_field("on_reverse", POS_W'(want.on_rev), POS_W'(got.on_rev));
                check_field("result_sub_base", POS_W'(want.sub), POS_W'(got.sub));
                check_field("result_contig_tag", POS_W'(want.tag), POS_W'(got.tag));
                check_field("target_position", want.pos, got.pos);
                check_field("all_done", POS_W'(want.done), POS_W'(got.done));
            end
        end
        if (start && busy === 1'b0)
        begin
            if (cmd.op == OP_QUERY)
            begin
                want = scan_contexts(cmd);
                n_queries++;
                n_fwd_hits  += int'(want.matched && !want.on_rev);
                n_rev_hits  += int'(want.matched && want.on_rev);
                n_done_high += int'(want.done);
                if (pinned)
                    want = pinned_want;
                pending_results.push_back(want);
            end
            else
            begin
                store_context(cmd);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send(input item_t it, input logic pin, input result_t want);
        logic quiet;
        cmd         <= it;
        pinned      <= pin;
        pinned_want <= want;
        start       <= 1'b1;
        useful_items++;
        if (it.op == OP_LOAD && load_log.size() < DEPTH)
        begin
            load_log.push_back({it.base_left, it.base_mid, it.base_right});
        end
        do
            @(posedge clk);
        while (busy !== 1'b0);
        quiet = (useful_items >= 350) && (useful_items < 500);
        if (!quiet && $urandom_range(0, 99) < 14)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic hold_until_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic send_random_load();
        item_t it;
        int    pick;
        it       = '0;
        it.op    = OP_LOAD;
        it.sub   = SUB_W'($urandom_range(0, 3));
        it.tag   = TAG_W'($urandom);
        it.pos   = POS_W'({$urandom, $urandom});
        it.base_left  = BASE_W'($urandom_range(0, 3));
        it.base_mid   = BASE_W'($urandom_range(0, 3));
        it.base_right = BASE_W'($urandom_range(0, 3));
        pick = $urandom_range(0, 19);
        it.quota = (pick < 2) ? 32'd0 : (pick == 19) ? $urandom_range(4, 9) : $urandom_range(1, 3);
        if (load_log.size() >= DEPTH)
        begin
            it.quota = $urandom;
            it.base_left = BASE_W'($urandom_range(0, 4));
        end
        else if (load_log.size() == DEPTH - 2)
        begin
            // An entry with an unknown base holds its quota for the rest of the run.
            it.base_mid = NT_N;
            it.quota    = $urandom | 32'd1;
        end
        else if (load_log.size() == DEPTH - 1)
        begin
            it.quota = 32'hFFFF_FFFF;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            it.base_right = NT_N;
            it.quota      = 32'd0;
        end
        send(it, 1'b0, '0);
    endtask

    task automatic send_random_query();
        item_t               it;
        logic [3*BASE_W-1:0] ctx;
        logic [BASE_W-1:0]   b0, b1, b2;
        it       = '0;
        it.op    = OP_QUERY;
        it.sub   = SUB_W'($urandom_range(0, 3));
        it.quota = $urandom;
        it.tag   = TAG_W'($urandom);
        it.pos   = ($urandom_range(0, 19) == 0) ? '1 : POS_W'({$urandom, $urandom});
        it.base_left  = BASE_W'($urandom_range(0, 4));
        it.base_mid   = BASE_W'($urandom_range(0, 4));
        it.base_right = BASE_W'($urandom_range(0, 4));
        if (load_log.size() != 0 && $urandom_range(0, 3) != 0)
        begin
            ctx = load_log[$urandom_range(0, load_log.size() - 1)];
            {b0, b1, b2} = ctx;
            if (b0 <= NT_T && b1 <= NT_T && b2 <= NT_T && $urandom_range(0, 1) == 1)
                {it.base_left, it.base_mid, it.base_right} = {flip_base(b2), flip_base(b1),
                                                              flip_base(b0)};
            else
                {it.base_left, it.base_mid, it.base_right} = ctx;
        end
        send(it, 1'b0, '0);
    endtask

    initial
    begin
        int round;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (DIRECTED[i])
            send(DIRECTED[i].cmd, DIRECTED[i].pinned, DIRECTED[i].want);
        round = 0;
        while (useful_items < N_ITEMS)
        begin
            repeat ($urandom_range(1, 4)) send_random_load();
            repeat ($urandom_range(3, 12)) send_random_query();
            if (round % 9 == 4)
                hold_until_drained();
            round++;
        end
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 8) @(posedge clk);
        $display("Ran %0d queries: %0d forward hits, %0d reverse hits, %0d with every quota spent.",
                 n_queries, n_fwd_hits, n_rev_hits, n_done_high);
        $display("Stored %0d contexts and sent %0d loads to a full table.", ctx_loaded,
                 n_full_loads);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
